@@ rtl/sjt_pkg.sv @@
// Shared types, constants and the pair-mapping function of the Shift-JIS
// title decoder. No dependencies; every other file of the block imports it.
package sjt_pkg;

  localparam logic [7:0] BYTE_NUL      = 8'h00;
  localparam logic [7:0] ASCII_LO      = 8'h20;
  localparam logic [7:0] ASCII_HI      = 8'h7D;
  localparam logic [7:0] LEAD_PUNCT    = 8'h81;
  localparam logic [7:0] LEAD_ALNUM    = 8'h82;
  localparam logic [7:0] PUNCT_LO      = 8'h40;
  localparam logic [7:0] PUNCT_HI      = 8'h49;
  localparam logic [7:0] TRAIL_DASH    = 8'h7C;
  localparam logic [7:0] DIGIT_LO      = 8'h4F;
  localparam logic [7:0] DIGIT_HI      = 8'h58;
  localparam logic [7:0] UPPER_LO      = 8'h60;
  localparam logic [7:0] UPPER_HI      = 8'h79;
  localparam logic [7:0] LOWER_LO      = 8'h81;
  localparam logic [7:0] LOWER_HI      = 8'h9A;
  localparam logic [6:0] CHAR_NUL      = 7'h00;
  localparam logic [6:0] CHAR_SPACE    = 7'h20;
  localparam logic [6:0] CHAR_DASH     = 7'h2D;
  localparam logic [6:0] CHAR_ZERO     = 7'h30;
  localparam logic [6:0] CHAR_UPPER_A  = 7'h41;
  localparam logic [6:0] CHAR_LOWER_A  = 7'h61;

  // One input item as held in the input register.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_title;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [6:0] ascii_char;
    logic       last_char;
    logic       unmapped;
  } result_t;

  // Full-width punctuation in the 0x8140..0x8149 range.
  function automatic logic [6:0] punct_char(input logic [3:0] idx);
    logic [6:0] ch;
    unique case (idx)
      4'd0:    ch = 7'h20;
      4'd1:    ch = 7'h2C;
      4'd2:    ch = 7'h2E;
      4'd3:    ch = 7'h2C;
      4'd4:    ch = 7'h2E;
      4'd5:    ch = 7'h20;
      4'd6:    ch = 7'h3A;
      4'd7:    ch = 7'h3B;
      4'd8:    ch = 7'h3F;
      4'd9:    ch = 7'h21;
      default: ch = CHAR_NUL;
    endcase
    return ch;
  endfunction

  // Maps a lead/trail pair to ASCII; zero means the pair is not known.
  function automatic logic [6:0] map_pair(input logic [7:0] b1, input logic [7:0] b2);
    logic [6:0] ch;
    logic [7:0] off;
    ch  = CHAR_NUL;
    off = 8'd0;
    if (b1 == LEAD_PUNCT) begin
      if (b2 >= PUNCT_LO && b2 <= PUNCT_HI) begin
        off = b2 - PUNCT_LO;
        ch  = punct_char(off[3:0]);
      end else if (b2 == TRAIL_DASH) begin
        ch = CHAR_DASH;
      end
    end else if (b1 == LEAD_ALNUM) begin
      if (b2 >= DIGIT_LO && b2 <= DIGIT_HI) begin
        off = b2 - DIGIT_LO;
        ch  = CHAR_ZERO + off[6:0];
      end else if (b2 >= UPPER_LO && b2 <= UPPER_HI) begin
        off = b2 - UPPER_LO;
        ch  = CHAR_UPPER_A + off[6:0];
      end else if (b2 >= LOWER_LO && b2 <= LOWER_HI) begin
        off = b2 - LOWER_LO;
        ch  = CHAR_LOWER_A + off[6:0];
      end
    end
    return ch;
  endfunction

endpackage

@@ rtl/sjt_in_stage.sv @@
// Input register of the Shift-JIS title decoder.
// Depends on sjt_pkg for the item type.
module sjt_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sjt_pkg::item_t in_item,
  input  logic           advance,
  output logic           held_valid,
  output sjt_pkg::item_t held_item
);
  import sjt_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  load;

  // The register takes a new item when empty or when its item moves on.
  assign in_stall  = valid_r && !advance;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign held_valid = valid_r;
  assign held_item  = item_r;

endmodule

@@ rtl/sjt_core.sv @@
// Decoder state (pending lead byte, position, end flag) and the per-byte
// decode. Depends on sjt_pkg for types, constants and the pair mapping.
module sjt_core #(
  parameter int TITLE_BYTES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  sjt_pkg::item_t   item,
  output logic             res_valid,
  output sjt_pkg::result_t res
);
  import sjt_pkg::*;

  localparam int POS_W = (TITLE_BYTES > 2) ? $clog2(TITLE_BYTES) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(TITLE_BYTES - 1);

  logic             pend_r, pend_nxt;
  logic [7:0]       lead_r, lead_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             done_r, done_nxt;

  logic             pend_eff;
  logic [POS_W-1:0] pos_eff;
  logic             done_eff;
  logic             last;
  logic [6:0]       pair_ch;
  logic [7:0]       b;

  // A start flag clears the state before this byte is looked at.
  assign b        = item.byte_value;
  assign pend_eff = item.start_title ? 1'b0 : pend_r;
  assign pos_eff  = item.start_title ? '0 : pos_r;
  assign done_eff = item.start_title ? 1'b0 : done_r;
  assign last     = (pos_eff == POS_LAST);
  assign pair_ch  = map_pair(lead_r, b);

  always_comb begin
    pend_nxt  = pend_eff;
    lead_nxt  = lead_r;
    pos_nxt   = pos_eff;
    done_nxt  = done_eff;
    res_valid = 1'b0;
    res       = '{ascii_char: CHAR_SPACE, last_char: 1'b0, unmapped: 1'b0};
    if (!done_eff) begin
      pos_nxt  = last ? '0 : pos_eff + POS_W'(1);
      done_nxt = last;
      if (pend_eff) begin
        pend_nxt  = 1'b0;
        res_valid = 1'b1;
        if (pair_ch == CHAR_NUL) begin
          res = '{ascii_char: CHAR_SPACE, last_char: last, unmapped: 1'b1};
        end else begin
          res = '{ascii_char: pair_ch, last_char: last, unmapped: 1'b0};
        end
      end else if (b == BYTE_NUL) begin
        done_nxt  = 1'b1;
        res_valid = 1'b1;
        res       = '{ascii_char: CHAR_NUL, last_char: 1'b1, unmapped: 1'b0};
      end else if (b >= ASCII_LO && b <= ASCII_HI) begin
        res_valid = 1'b1;
        res       = '{ascii_char: b[6:0], last_char: last, unmapped: 1'b0};
      end else if (last) begin
        // A lead byte with no room left for its trail byte.
        res_valid = 1'b1;
        res       = '{ascii_char: CHAR_SPACE, last_char: 1'b1, unmapped: 1'b1};
      end else begin
        lead_nxt = b;
        pend_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      pos_r  <= '0;
      done_r <= 1'b0;
    end else if (advance) begin
      pend_r <= pend_nxt;
      pos_r  <= pos_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lead_r <= lead_nxt;
    end
  end

endmodule

@@ rtl/shift_jis_title_to_ascii_unit.sv @@
// Top level of the Shift-JIS title decoder: input register, decode core
// and result register. Depends on sjt_pkg, sjt_in_stage and sjt_core.
module shift_jis_title_to_ascii_unit #(
  parameter int TITLE_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_value,
  input  logic       in_start_title,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_ascii_char,
  output logic       out_last_char,
  output logic       out_unmapped
);
  // This unit turns a fixed-size Shift-JIS title field, presented one byte
  // per item, into plain ASCII characters. Printable single bytes pass
  // through; full-width punctuation, digits and letters (lead bytes 0x81 and
  // 0x82) are folded to their ASCII forms; any other two-byte pair becomes a
  // space with out_unmapped set. A lead byte produces no result item of its
  // own but in the last position, where it gives an unmapped space; the
  // character comes with the trail byte. A zero lead byte gives a NUL with
  // out_last_char set, and the byte that completes TITLE_BYTES bytes also
  // carries out_last_char. Bytes after the end of a title yield nothing
  // until an item arrives with in_start_title set, which also drops any
  // held lead byte. Each item passes the input register, then the result
  // register; a new item is taken every cycle unless out_stall holds the output.
  // in_stall rises only when both registers are full and out_stall is high.
  import sjt_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  logic    res_valid;
  result_t res;
  logic    out_valid_r, out_valid_nxt;
  result_t out_r;
  logic    out_free;

  assign in_item  = '{byte_value: in_byte_value, start_title: in_start_title};

  // The result register is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = held_valid && out_free;

  sjt_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  sjt_core #(
    .TITLE_BYTES (TITLE_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_valid_nxt = out_free ? (advance && res_valid) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ascii_char = out_r.ascii_char;
  assign out_last_char  = out_r.last_char;
  assign out_unmapped   = out_r.unmapped;

endmodule
